/* rtl/sha256_pkg.sv */
// Shared types, constants and round functions for the SHA-256 stream hasher.
package sha256_pkg;

  localparam int CountBits = 61;
  localparam int CntW = CountBits;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMP,
    ST_PAD,
    ST_EMIT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic       load_byte;
    logic       pad_fill;
    logic       comp_start;
    logic       comp_step;
    logic       comp_fold;
    logic       reset_msg;
    logic       out_load;
    logic [2:0] out_index;
    logic       out_last;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic       block_full;
    logic       pad_two;
    logic [5:0] round;
    logic       round_done;
  } status_t;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [6:0] LEN_OFFSET = 7'd56;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

endpackage

/* rtl/sha256_ctrl.sv */
// Controller: sequences byte intake, padding, compression and digest output.
module sha256_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_byte_valid,
  input  logic                in_last,
  output logic                out_valid,
  input  logic                out_ready,
  input  sha256_pkg::status_t status,
  output sha256_pkg::cmd_t    cmd
);

  sha256_pkg::state_t state, state_next;
  logic       pending_last, pending_last_next;
  logic       padded, padded_next;
  logic [2:0] out_cnt, out_cnt_next;
  logic       ovalid, ovalid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha256_pkg::ST_IDLE;
      pending_last <= 1'b0;
      padded <= 1'b0;
      out_cnt <= '0;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      pending_last <= pending_last_next;
      padded <= padded_next;
      out_cnt <= out_cnt_next;
      ovalid <= ovalid_next;
    end
  end

  logic accept;
  assign accept = in_valid && in_ready;
  assign in_ready = (state == sha256_pkg::ST_IDLE);
  assign out_valid = ovalid;

  // Next state.
  always_comb begin
    state_next = state;
    pending_last_next = pending_last;
    padded_next = padded;
    out_cnt_next = out_cnt;
    ovalid_next = ovalid;
    case (state)
      sha256_pkg::ST_IDLE: begin
        if (accept) begin
          pending_last_next = in_last;
          padded_next = 1'b0;
          if (in_byte_valid && status.block_full) state_next = sha256_pkg::ST_COMP;
          else if (in_last) state_next = sha256_pkg::ST_PAD;
        end
      end
      sha256_pkg::ST_PAD: begin
        padded_next = !status.pad_two;
        state_next = sha256_pkg::ST_COMP;
      end
      sha256_pkg::ST_COMP: begin
        if (status.round_done) begin
          if (!pending_last) state_next = sha256_pkg::ST_IDLE;
          else if (!padded) state_next = sha256_pkg::ST_PAD;
          else begin
            state_next = sha256_pkg::ST_EMIT;
            out_cnt_next = '0;
            ovalid_next = 1'b0;
          end
        end
      end
      sha256_pkg::ST_EMIT: begin
        if (!ovalid) ovalid_next = 1'b1;
        else if (out_ready) begin
          if (out_cnt == 3'd7) begin
            ovalid_next = 1'b0;
            state_next = sha256_pkg::ST_IDLE;
            pending_last_next = 1'b0;
          end else begin
            out_cnt_next = out_cnt + 3'd1;
            ovalid_next = 1'b0;
          end
        end
      end
      default: state_next = sha256_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd = '0;
    cmd.out_index = out_cnt;
    cmd.out_last = (out_cnt == 3'd7);
    case (state)
      sha256_pkg::ST_IDLE: begin
        cmd.load_byte = accept && in_byte_valid;
        cmd.comp_start = accept && in_byte_valid && status.block_full;
      end
      sha256_pkg::ST_PAD: begin
        cmd.pad_fill = 1'b1;
        cmd.comp_start = 1'b1;
      end
      sha256_pkg::ST_COMP: begin
        cmd.comp_step = 1'b1;
        cmd.comp_fold = status.round_done;
      end
      sha256_pkg::ST_EMIT: begin
        cmd.out_load = !ovalid;
        cmd.reset_msg = ovalid && out_ready && (out_cnt == 3'd7);
      end
      default: cmd = '0;
    endcase
  end

endmodule

/* rtl/sha256_dp.sv */
// Datapath: block buffer, message schedule, round unit, hash state and output word.
module sha256_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          data_byte,
  input  sha256_pkg::cmd_t    cmd,
  output sha256_pkg::status_t status,
  output logic [31:0]         digest_word,
  output logic [2:0]          word_index,
  output logic                last_word
);

  logic [31:0] buf_q [16];
  logic [6:0]  count;
  logic [sha256_pkg::CntW-1:0] msg_bytes;
  logic [31:0] hash [8];
  logic [31:0] hash_fold [8];
  logic [31:0] v [8];
  logic [31:0] w [16];
  logic [5:0]  round;
  logic        fill_two;
  logic        fold_pend;

  assign status.block_full = (count == 7'd63);
  assign status.pad_two = (count >= 7'd56);
  assign status.round = round;
  assign status.round_done = (round == 6'd63);

  // Padded block view: 0x80 at count, zeros, then length in the final block.
  logic [63:0] bit_len;
  assign bit_len = {msg_bytes, 3'b000};

  function automatic logic [7:0] pad_at(input int i, input logic [6:0] c,
                                        input logic two, input logic second,
                                        input logic [63:0] len, input logic [7:0] cur);
    logic [6:0] ii;
    ii = 7'(i);
    // The second padded block holds only zeros and the length.
    if (second) pad_at = (ii < sha256_pkg::LEN_OFFSET) ? 8'h00 : len[8*(63-i) +: 8];
    else if (ii < c) pad_at = cur;
    else if (ii == c) pad_at = sha256_pkg::PAD_BYTE;
    else if (two || ii < sha256_pkg::LEN_OFFSET) pad_at = 8'h00;
    else pad_at = len[8*(63-i) +: 8];
  endfunction

  logic [7:0] blk [64];
  always_comb begin
    for (int j = 0; j < 16; j++) begin
      for (int k = 0; k < 4; k++) begin
        blk[4*j+k] = cmd.pad_fill
          ? pad_at(4*j+k, count, status.pad_two, fill_two, bit_len, buf_q[j][8*(3-k) +: 8])
          : buf_q[j][8*(3-k) +: 8];
      end
    end
    if (cmd.load_byte) blk[63] = data_byte;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_byte) buf_q[count[5:2]][{~count[1:0], 3'b000} +: 8] <= data_byte;
    if (cmd.pad_fill) begin
      for (int i = 0; i < 16; i++)
        buf_q[i] <= {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.reset_msg) begin
      count <= '0;
      msg_bytes <= '0;
      fill_two <= 1'b0;
    end else begin
      if (cmd.load_byte) begin
        msg_bytes <= msg_bytes + 1'b1;
        count <= (count == 7'd63) ? 7'd0 : count + 7'd1;
      end
      // After the first padded block the rest is zeros plus length.
      if (cmd.pad_fill) begin
        fill_two <= status.pad_two;
        count <= status.pad_two ? 7'd0 : count;
      end
    end
  end

  // Schedule: 16-word window, one new word per round.
  logic [31:0] s0, s1, w_new, wt;
  assign s0 = sha256_pkg::ror(w[1], 7) ^ sha256_pkg::ror(w[1], 18) ^ (w[1] >> 3);
  assign s1 = sha256_pkg::ror(w[14], 17) ^ sha256_pkg::ror(w[14], 19) ^ (w[14] >> 10);
  assign w_new = w[0] + s0 + w[9] + s1;
  assign wt = w[0];

  logic [31:0] t1, t2, ch, maj, e1, a0;
  assign e1 = sha256_pkg::ror(v[4], 6) ^ sha256_pkg::ror(v[4], 11) ^ sha256_pkg::ror(v[4], 25);
  assign ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign a0 = sha256_pkg::ror(v[0], 2) ^ sha256_pkg::ror(v[0], 13) ^ sha256_pkg::ror(v[0], 22);
  assign maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign t1 = v[7] + e1 + ch + sha256_pkg::ROUND_K[round] + wt;
  assign t2 = a0 + maj;

  // Fold registers after the last round; the fold uses the round-63 outputs.
  always_ff @(posedge clk) begin
    if (rst) fold_pend <= 1'b0;
    else fold_pend <= cmd.comp_fold;
  end

  // Forward a pending fold to the next block start and the digest load.
  always_comb begin
    for (int i = 0; i < 8; i++) hash_fold[i] = fold_pend ? hash[i] + v[i] : hash[i];
  end

  always_ff @(posedge clk) begin
    if (cmd.comp_start) begin
      for (int i = 0; i < 16; i++)
        w[i] <= {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      for (int i = 0; i < 8; i++) v[i] <= hash_fold[i];
    end else if (cmd.comp_step) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= w_new;
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) round <= '0;
    else if (cmd.comp_start) round <= '0;
    else if (cmd.comp_step) round <= round + 6'd1;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.reset_msg) begin
      for (int i = 0; i < 8; i++) hash[i] <= sha256_pkg::INIT_HASH[i];
    end else if (fold_pend) begin
      for (int i = 0; i < 8; i++) hash[i] <= hash_fold[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      digest_word <= hash_fold[cmd.out_index];
      word_index <= cmd.out_index;
      last_word <= cmd.out_last;
    end
  end

endmodule

/* rtl/sha256_stream_hasher_unit.sv */
// A byte that fills no block is taken while idle; a full block adds 64 rounds
// plus a fold. Last adds a pad step and 64 rounds (twice when the length
// does not fit), then eight digest transactions.
// Throughput: one item while idle and no fold is pending; the single round unit runs one round per cycle.
// Reset: synchronous rst restores the initial hash, clears counts and output valid.
module sha256_stream_hasher_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  sha256_pkg::cmd_t    cmd;
  sha256_pkg::status_t status;
  logic ctrl_ready, fold_busy;

  // Input is held off after each compression while the hash fold lands.
  always_ff @(posedge clk) begin
    if (rst) fold_busy <= 1'b0;
    else fold_busy <= cmd.comp_fold;
  end
  assign in_ready = ctrl_ready && !fold_busy;

  sha256_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid && !fold_busy), .in_ready(ctrl_ready),
    .in_byte_valid(byte_valid), .in_last(last),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .cmd(cmd)
  );

  sha256_dp u_dp (
    .clk(clk), .rst(rst), .data_byte(data_byte),
    .cmd(cmd), .status(status),
    .digest_word(digest_word), .word_index(word_index), .last_word(last_word)
  );

endmodule

/* rtl/sha256_checker.sv */
// Port-level checker for the SHA-256 stream hasher, bound to the top level.
module sha256_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  word_index,
  input logic        last_word
);

  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken during digest output");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_word == (word_index == 3'd7))) else $error("last_word mismatch");

  a_index_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_word |=> ##1 (out_valid && word_index == $past(word_index, 2) + 3'd1))
    else $error("digest word order broken");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(word_index))
    else $error("output dropped before transaction");

endmodule

bind sha256_stream_hasher_unit sha256_checker u_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .word_index(word_index), .last_word(last_word)
);
